// File: design/fld_pkg.sv
package fld_pkg;

  typedef logic [15:0] word_t;

  // Lane order inside the filter bank
  localparam int unsigned LANES     = 4;
  localparam int unsigned LN_PITCH  = 0;
  localparam int unsigned LN_ROLL   = 1;
  localparam int unsigned LN_VVX    = 2;
  localparam int unsigned LN_VVY    = 3;

  // Configuration register indexes
  localparam logic [2:0] REG_SAMPLE_INTERVAL = 3'd0;
  localparam logic [2:0] REG_PITCH_TAU       = 3'd1;
  localparam logic [2:0] REG_ROLL_TAU        = 3'd2;
  localparam logic [2:0] REG_VVX_TAU         = 3'd3;
  localparam logic [2:0] REG_VVY_TAU         = 3'd4;

  // Reset values of the registers
  localparam word_t DT_RESET  = 16'd1;
  localparam word_t TAU_RESET = 16'd15;

  // Frame conditioning constants
  localparam word_t ATT_MASK    = 16'hfff0;
  localparam word_t VV_MASK     = 16'hffc0;
  localparam word_t ALT_INVALID = 16'h8000;
  localparam word_t ALT_OFFSET  = 16'd31512;
  localparam int unsigned ATT_SHIFT = 4;
  localparam int unsigned VV_SHIFT  = 6;
  localparam int unsigned HDG_SHIFT = 4;

  // Quotient bits produced by the serial divider, one per cycle
  localparam int unsigned DIV_STEPS = 32;

  // Command into one filter lane
  typedef struct packed {
    logic  start;
    word_t target;
    word_t tau;
    word_t dt;
  } lane_ctl_t;

  // Status out of one filter lane
  typedef struct packed {
    logic  done;
    word_t acc;
  } lane_sts_t;

endpackage

// File: design/fld_lane.sv
module fld_lane (
  input  logic              clk,
  input  logic              rst_n,
  input  fld_pkg::lane_ctl_t ctl,
  output fld_pkg::lane_sts_t sts
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam int unsigned CNT_W = $clog2(fld_pkg::DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(fld_pkg::DIV_STEPS - 1);

  logic [1:0]          state_r, state_nxt;
  logic                done_r, done_nxt;
  fld_pkg::word_t      acc_r, acc_nxt;
  logic signed [16:0]  diff_r, diff_nxt;
  logic [16:0]         den_r, den_nxt;
  fld_pkg::word_t      dt_r, dt_nxt;
  logic                neg_r, neg_nxt;
  logic [31:0]         num_r, num_nxt;
  logic [16:0]         rem_r, rem_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  logic [16:0] mag;
  logic [32:0] prod;
  logic [17:0] rem_sh;
  logic        qbit;
  fld_pkg::word_t quo;

  // Magnitude of the error times the time step
  assign mag  = diff_r[16] ? 17'(~diff_r + 17'sd1) : 17'(diff_r);
  assign prod = {16'b0, mag} * {17'b0, dt_r};

  // One restoring division step
  assign rem_sh = {rem_r, num_r[31]};
  assign qbit   = (rem_sh >= {1'b0, den_r});

  // Signed quotient; a zero denominator gives no update
  always_comb begin
    quo = (den_r == 17'd0) ? 16'd0 : num_r[15:0];
    if (neg_r) begin
      quo = 16'(~quo + 16'd1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    done_nxt  = done_r;
    acc_nxt   = acc_r;
    diff_nxt  = diff_r;
    den_nxt   = den_r;
    dt_nxt    = dt_r;
    neg_nxt   = neg_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (ctl.start) begin
          diff_nxt  = $signed({ctl.target[15], ctl.target}) - $signed({acc_r[15], acc_r});
          den_nxt   = {1'b0, ctl.tau} + {1'b0, ctl.dt};
          dt_nxt    = ctl.dt;
          done_nxt  = 1'b0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        neg_nxt   = diff_r[16];
        num_nxt   = prod[31:0];
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = qbit ? 17'(rem_sh - {1'b0, den_r}) : rem_sh[16:0];
        num_nxt = {num_r[30:0], qbit};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        acc_nxt   = acc_r + quo;
        done_nxt  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
      acc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    den_r  <= den_nxt;
    dt_r   <= dt_nxt;
    neg_r  <= neg_nxt;
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign sts.done = done_r;
  assign sts.acc  = acc_r;

endmodule

// File: design/fld_merge.sv
module fld_merge (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     capture,
  input  fld_pkg::word_t           heading_raw,
  input  fld_pkg::word_t           altitude_raw,
  input  fld_pkg::word_t           true_speed_raw,
  input  fld_pkg::word_t           indicated_speed_raw,
  input  logic                     results_ready,
  input  fld_pkg::word_t           acc [fld_pkg::LANES],
  output logic                     load,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [11:0]       pitch_out,
  output logic signed [11:0]       roll_out,
  output logic signed [9:0]        vvx_out,
  output logic signed [9:0]        vvy_out,
  output logic [11:0]              heading_out,
  output logic [15:0]              altitude_out,
  output logic [14:0]              true_speed_out,
  output logic [14:0]              indicated_speed_out
);

  logic [15:0] held_alt_r, held_alt_nxt;
  logic [14:0] held_tas_r, held_tas_nxt;
  logic [14:0] held_ias_r, held_ias_nxt;
  logic [11:0] hdg_r;
  logic        out_valid_r, out_valid_nxt;
  logic signed [11:0] pitch_r, roll_r;
  logic signed [9:0]  vvx_r, vvy_r;
  logic [11:0] hdg_out_r;
  logic [15:0] alt_out_r;
  logic [14:0] tas_out_r, ias_out_r;

  // Load the output register once it is empty or being taken
  assign load = results_ready && (!out_valid_r || !out_stall);

  // Update held words as the item is accepted
  always_comb begin
    held_alt_nxt = held_alt_r;
    held_tas_nxt = held_tas_r;
    held_ias_nxt = held_ias_r;
    if (capture) begin
      if (altitude_raw != fld_pkg::ALT_INVALID) begin
        held_alt_nxt = altitude_raw + fld_pkg::ALT_OFFSET;
      end
      if (!true_speed_raw[0]) begin
        held_tas_nxt = true_speed_raw[15:1];
      end
      if (!indicated_speed_raw[0]) begin
        held_ias_nxt = indicated_speed_raw[15:1];
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_alt_r  <= '0;
      held_tas_r  <= '0;
      held_ias_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      held_alt_r  <= held_alt_nxt;
      held_tas_r  <= held_tas_nxt;
      held_ias_r  <= held_ias_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the heading of the item in flight
  always_ff @(posedge clk) begin
    if (capture) begin
      hdg_r <= heading_raw[15:fld_pkg::HDG_SHIFT];
    end
  end

  // Merge lane results with the side words
  always_ff @(posedge clk) begin
    if (load) begin
      pitch_r   <= acc[fld_pkg::LN_PITCH][15:fld_pkg::ATT_SHIFT];
      roll_r    <= acc[fld_pkg::LN_ROLL][15:fld_pkg::ATT_SHIFT];
      vvx_r     <= acc[fld_pkg::LN_VVX][15:fld_pkg::VV_SHIFT];
      vvy_r     <= acc[fld_pkg::LN_VVY][15:fld_pkg::VV_SHIFT];
      hdg_out_r <= hdg_r;
      alt_out_r <= held_alt_r;
      tas_out_r <= held_tas_r;
      ias_out_r <= held_ias_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign pitch_out           = pitch_r;
  assign roll_out            = roll_r;
  assign vvx_out             = vvx_r;
  assign vvy_out             = vvy_r;
  assign heading_out         = hdg_out_r;
  assign altitude_out        = alt_out_r;
  assign true_speed_out      = tas_out_r;
  assign indicated_speed_out = ias_out_r;

endmodule

// File: design/flight_data_lag_filter.sv
// Flight-data frame conditioner with four first-order lag filters.
//
// Input channel (in_*): one frame of eight 16-bit words per item, taken at
// an edge with in_valid high and in_stall low. in_stall is high while a
// frame is being filtered, so one frame is in work at a time.
// Result channel (out_*): one conditioned frame per input frame, taken at an
// edge with out_valid high and out_stall low. The output register keeps the
// result while out_stall is high; the next frame can be accepted and filtered
// meanwhile, and its result waits in the lanes until the register frees.
// Config channel (cfg_*): cfg_ready is always high; write only while idle.
// The four lanes run in parallel; each takes the error at the accepting edge,
// then does the multiply by the time step, the bit-serial divide by tau + dt
// and the accumulator update in turn; then the output register is loaded and
// out_valid rises. in_stall drops with that load, so a new frame is accepted
// only once the previous result has moved to the output register; that move
// waits while the output is stalled.
// Reset (rst_n low, synchronous): accumulators and held altitude and speeds
// clear to zero, time step to 1, all time constants to 15; no result pending.
module flight_data_lag_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_pitch_raw,
  input  logic signed [15:0] in_roll_raw,
  input  logic signed [15:0] in_vvx_raw,
  input  logic signed [15:0] in_vvy_raw,
  input  logic [15:0]        in_heading_raw,
  input  logic [15:0]        in_altitude_raw,
  input  logic [15:0]        in_true_speed_raw,
  input  logic [15:0]        in_indicated_speed_raw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [11:0] out_pitch_out,
  output logic signed [11:0] out_roll_out,
  output logic signed [9:0]  out_vvx_out,
  output logic signed [9:0]  out_vvy_out,
  output logic [11:0]        out_heading_out,
  output logic [15:0]        out_altitude_out,
  output logic [14:0]        out_true_speed_out,
  output logic [14:0]        out_indicated_speed_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  fld_pkg::word_t dt_r, dt_nxt;
  fld_pkg::word_t tau_r   [fld_pkg::LANES];
  fld_pkg::word_t tau_nxt [fld_pkg::LANES];
  logic           busy_r, busy_nxt;
  logic           in_acc;
  logic           cfg_wr;
  logic           load;
  logic           results_ready;
  logic [fld_pkg::LANES-1:0] lane_done;

  fld_pkg::lane_ctl_t lane_ctl [fld_pkg::LANES];
  fld_pkg::lane_sts_t lane_sts [fld_pkg::LANES];
  fld_pkg::word_t     lane_acc [fld_pkg::LANES];
  fld_pkg::word_t     lane_tgt [fld_pkg::LANES];

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = busy_r;
  assign in_acc    = in_valid && !busy_r;

  // Register writes; unknown indexes drop
  always_comb begin
    dt_nxt  = dt_r;
    tau_nxt = tau_r;
    if (cfg_wr) begin
      case (cfg_index)
        fld_pkg::REG_SAMPLE_INTERVAL: dt_nxt = cfg_data;
        fld_pkg::REG_PITCH_TAU:       tau_nxt[fld_pkg::LN_PITCH] = cfg_data;
        fld_pkg::REG_ROLL_TAU:        tau_nxt[fld_pkg::LN_ROLL]  = cfg_data;
        fld_pkg::REG_VVX_TAU:         tau_nxt[fld_pkg::LN_VVX]   = cfg_data;
        fld_pkg::REG_VVY_TAU:         tau_nxt[fld_pkg::LN_VVY]   = cfg_data;
        default: ;
      endcase
    end
  end

  // Busy from acceptance until the result moves to the output register
  always_comb begin
    busy_nxt = busy_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
    end else if (load) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r   <= fld_pkg::DT_RESET;
      tau_r  <= '{default: fld_pkg::TAU_RESET};
      busy_r <= 1'b0;
    end else begin
      dt_r   <= dt_nxt;
      tau_r  <= tau_nxt;
      busy_r <= busy_nxt;
    end
  end

  // Masked filter targets
  assign lane_tgt[fld_pkg::LN_PITCH] = in_pitch_raw & fld_pkg::ATT_MASK;
  assign lane_tgt[fld_pkg::LN_ROLL]  = in_roll_raw  & fld_pkg::ATT_MASK;
  assign lane_tgt[fld_pkg::LN_VVX]   = in_vvx_raw   & fld_pkg::VV_MASK;
  assign lane_tgt[fld_pkg::LN_VVY]   = in_vvy_raw   & fld_pkg::VV_MASK;

  for (genvar g = 0; g < fld_pkg::LANES; g++) begin : g_lane
    assign lane_ctl[g].start  = in_acc;
    assign lane_ctl[g].target = lane_tgt[g];
    assign lane_ctl[g].tau    = tau_r[g];
    assign lane_ctl[g].dt     = dt_r;
    assign lane_done[g]       = lane_sts[g].done;
    assign lane_acc[g]        = lane_sts[g].acc;

    fld_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (lane_ctl[g]),
      .sts   (lane_sts[g])
    );
  end

  assign results_ready = busy_r && (&lane_done);

  fld_merge u_merge (
    .clk                 (clk),
    .rst_n               (rst_n),
    .capture             (in_acc),
    .heading_raw         (in_heading_raw),
    .altitude_raw        (in_altitude_raw),
    .true_speed_raw      (in_true_speed_raw),
    .indicated_speed_raw (in_indicated_speed_raw),
    .results_ready       (results_ready),
    .acc                 (lane_acc),
    .load                (load),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .pitch_out           (out_pitch_out),
    .roll_out            (out_roll_out),
    .vvx_out             (out_vvx_out),
    .vvy_out             (out_vvy_out),
    .heading_out         (out_heading_out),
    .altitude_out        (out_altitude_out),
    .true_speed_out      (out_true_speed_out),
    .indicated_speed_out (out_indicated_speed_out)
  );

  // Lanes start together and so finish together
  a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_done == '0) || (lane_done == '1))
    else $error("filter lanes out of step");

  // A result is merged only for an item in work
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> busy_r)
    else $error("result loaded with no item in work");

  // An accepted item keeps the input stalled next cycle
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> busy_r)
    else $error("input not stalled after accept");

  // The output turns valid only from a merge
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(load))
    else $error("output valid without merge");

endmodule
